@@ rtl/tase_pkg.sv @@
// Shared types and constants for the Thumb subset executor.
// Used by tase_exec and thumb_alu_subset_executor; no dependencies.
package tase_pkg;

  typedef enum logic [2:0] {
    STATUS_OK         = 3'd0,
    STATUS_BAD_HIREG  = 3'd1,
    STATUS_BAD_ADDSUB = 3'd2,
    STATUS_BAD_IMM    = 3'd3,
    STATUS_UNHANDLED  = 3'd4
  } status_t;

  // Sub-operation codes inside each format
  localparam logic [1:0] ADDSUB_OP_ADD_IMM = 2'd2;
  localparam logic [1:0] IMM_OP_MOV        = 2'd0;
  localparam logic [1:0] IMM_OP_CMP        = 2'd1;
  localparam logic [1:0] HI_OP_MOV         = 2'd2;
  localparam logic [1:0] HI_OP_BX          = 2'd3;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_LR = 4'd14;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam int unsigned NUM_REGS = 15;

  typedef struct packed {
    status_t     status;
    logic        wr_en;
    logic [3:0]  wr_idx;
    logic [31:0] wr_val;
    logic [3:0]  flags;
    logic        br_taken;
    logic [31:0] br_target;
    logic        tbit;
  } exec_res_t;

endpackage

@@ rtl/tase_exec.sv @@
// Decode and execute of one Thumb instruction, purely combinational.
// Depends on tase_pkg; register file reads come in from the top level.
module tase_exec import tase_pkg::*; (
  input  logic [15:0] instr,
  input  logic [31:0] pc,
  input  logic [31:0] rd_data,
  input  logic [31:0] sp_data,
  input  logic [3:0]  flags,
  input  logic        tbit,
  output logic [3:0]  rd_idx,
  output exec_res_t   res
);

  function automatic logic [1:0] nz_of(input logic [31:0] v);
    return {v[31], (v == 32'd0)};
  endfunction

  logic is_addsub, is_imm, is_hireg, is_rel, is_spadj;

  assign is_addsub = (instr[15:11] == 5'b00011);
  assign is_imm    = (instr[15:13] == 3'b001);
  assign is_hireg  = (instr[15:10] == 6'b010001);
  assign is_rel    = (instr[15:12] == 4'b1010);
  assign is_spadj  = (instr[15:8] == 8'hB0);

  // One register read per instruction; sp has its own fixed tap
  always_comb begin
    if (is_addsub) begin
      rd_idx = {1'b0, instr[5:3]};
    end else if (is_imm) begin
      rd_idx = {1'b0, instr[10:8]};
    end else begin
      rd_idx = {instr[6], instr[5:3]};
    end
  end

  always_comb begin
    logic [32:0] sum;
    logic [31:0] r;
    logic [31:0] imm8;
    logic [31:0] off;
    logic [31:0] base;
    logic [3:0]  hi_rd;

    sum   = 33'd0;
    r     = 32'd0;
    imm8  = {24'd0, instr[7:0]};
    off   = {23'd0, instr[6:0], 2'b00};
    base  = 32'd0;
    hi_rd = {instr[7], instr[2:0]};

    res           = '0;
    res.status    = STATUS_OK;
    res.flags     = flags;
    res.tbit      = tbit;

    if (is_addsub) begin
      if (instr[10:9] != ADDSUB_OP_ADD_IMM) begin
        res.status = STATUS_BAD_ADDSUB;
      end else begin
        sum          = {1'b0, rd_data} + {30'd0, instr[8:6]};
        r            = sum[31:0];
        res.wr_en    = 1'b1;
        res.wr_idx   = {1'b0, instr[2:0]};
        res.wr_val   = r;
        // addend is small and positive: overflow only from positive to negative
        res.flags    = {nz_of(r), sum[32], ~rd_data[31] & r[31]};
      end
    end else if (is_imm) begin
      if (instr[12:11] == IMM_OP_MOV) begin
        res.wr_en  = 1'b1;
        res.wr_idx = {1'b0, instr[10:8]};
        res.wr_val = imm8;
        res.flags  = {nz_of(imm8), flags[1:0]};
      end else if (instr[12:11] == IMM_OP_CMP) begin
        sum       = {1'b0, rd_data} - {1'b0, imm8};
        r         = sum[31:0];
        // carry is the inverse of borrow
        res.flags = {nz_of(r), ~sum[32], rd_data[31] & ~r[31]};
      end else begin
        res.status = STATUS_BAD_IMM;
      end
    end else if (is_hireg) begin
      if (instr[9:8] == HI_OP_MOV) begin
        if (hi_rd == REG_PC) begin
          res.br_taken  = 1'b1;
          res.br_target = {rd_data[31:1], 1'b0};
        end else begin
          res.wr_en  = 1'b1;
          res.wr_idx = hi_rd;
          res.wr_val = rd_data;
        end
      end else if (instr[9:8] == HI_OP_BX) begin
        if (instr[7]) begin
          r          = pc - 32'd2;
          res.wr_en  = 1'b1;
          res.wr_idx = REG_LR;
          res.wr_val = {r[31:1], 1'b1};
        end
        res.br_taken  = 1'b1;
        res.br_target = {rd_data[31:1], 1'b0};
        res.tbit      = rd_data[0];
      end else begin
        res.status = STATUS_BAD_HIREG;
      end
    end else if (is_rel) begin
      base       = instr[11] ? sp_data : {pc[31:2], 2'b00};
      res.wr_en  = 1'b1;
      res.wr_idx = {1'b0, instr[10:8]};
      res.wr_val = base + {22'd0, instr[7:0], 2'b00};
    end else if (is_spadj) begin
      res.wr_en  = 1'b1;
      res.wr_idx = REG_SP;
      res.wr_val = instr[7] ? (sp_data - off) : (sp_data + off);
    end else begin
      res.status = STATUS_UNHANDLED;
    end
  end

endmodule

@@ rtl/thumb_alu_subset_executor.sv @@
// Top level of the Thumb subset executor: input register, register file,
// flags and T bit, result register. Depends on tase_pkg and tase_exec.

// Executes one 16-bit Thumb instruction per item at a sustained rate of one
// item per clock unless out_stall holds the result register. An accepted item
// sits in the input register, where decode, register read, one 32-bit add and
// write-back run; the result register captures the outcome at the same edge that
// updates r0..r14, the NZCV flags and the T bit, so dependent instructions issue
// back to back. An item passes the input register, then the result register,
// which raises out_valid. pc_value is read as r15. Reset clears r0..r14 and the
// flags and sets T.
module thumb_alu_subset_executor import tase_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] instr_word,
  input  logic [31:0] pc_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        reg_written,
  output logic [3:0]  dest_index,
  output logic [31:0] dest_value,
  output logic [3:0]  flags_out,
  output logic        branch_taken,
  output logic [31:0] branch_target,
  output logic        thumb_mode
);

  logic        in_q_valid;
  logic [15:0] instr_q;
  logic [31:0] pc_q;

  logic [31:0] reg_file [NUM_REGS];
  logic [3:0]  cond_flags;
  logic        thumb_bit;

  logic [3:0]  rd_idx;
  logic [31:0] rd_data;
  exec_res_t   res;
  exec_res_t   out_res;

  logic out_ready;
  logic fire;

  assign out_ready = !out_valid || !out_stall;
  assign fire      = in_q_valid && out_ready;
  assign in_stall  = in_q_valid && !fire;

  assign rd_data = (rd_idx == REG_PC) ? pc_q : reg_file[rd_idx];

  tase_exec u_exec (
    .instr   (instr_q),
    .pc      (pc_q),
    .rd_data (rd_data),
    .sp_data (reg_file[REG_SP]),
    .flags   (cond_flags),
    .tbit    (thumb_bit),
    .rd_idx  (rd_idx),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      instr_q <= instr_word;
      pc_q    <= pc_value;
    end
  end

  // Architectural state commits with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file[i] <= 32'd0;
      end
      cond_flags <= 4'd0;
      thumb_bit  <= 1'b1;
    end else if (fire) begin
      if (res.wr_en && res.wr_idx != REG_PC) begin
        reg_file[res.wr_idx] <= res.wr_val;
      end
      cond_flags <= res.flags;
      thumb_bit  <= res.tbit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= fire;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  assign status        = out_res.status;
  assign reg_written   = out_res.wr_en;
  assign dest_index    = out_res.wr_idx;
  assign dest_value    = out_res.wr_val;
  assign flags_out     = out_res.flags;
  assign branch_taken  = out_res.br_taken;
  assign branch_target = out_res.br_target;
  assign thumb_mode    = out_res.tbit;

`ifndef SYNTH
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register could advance");

  a_error_no_effect: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_OK) |-> (!reg_written && !branch_taken))
    else $error("failed instruction reports a write or branch");

  a_no_pc_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reg_written) |-> (dest_index != REG_PC))
    else $error("register write reported to r15");

  a_target_aligned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && branch_taken) |-> (branch_target[0] == 1'b0))
    else $error("branch target has bit 0 set");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for thumb_alu_subset_executor: directed and random Thumb items
// checked against an in-bench execution model. Depends on tase_pkg.
module tb;
  import tase_pkg::*;

  // Format prefixes of the Thumb encodings the block decodes
  localparam logic [4:0] FMT_ADDSUB = 5'b00011;
  localparam logic [2:0] FMT_IMM8   = 3'b001;
  localparam logic [5:0] FMT_HIREG  = 6'b010001;
  localparam logic [3:0] FMT_ADDR   = 4'b1010;
  localparam logic [7:0] FMT_SPADJ  = 8'b10110000;

  // Sub-operations the block rejects
  localparam logic [1:0] ADDSUB_OP_ADD_REG = 2'd0;
  localparam logic [1:0] ADDSUB_OP_SUB_REG = 2'd1;
  localparam logic [1:0] ADDSUB_OP_SUB_IMM = 2'd3;
  localparam logic [1:0] IMM_OP_ADD        = 2'd2;
  localparam logic [1:0] IMM_OP_SUB        = 2'd3;
  localparam logic [1:0] HI_OP_ADD         = 2'd0;
  localparam logic [1:0] HI_OP_CMP         = 2'd1;

  localparam int FLAG_C = 1;
  localparam int FLAG_V = 0;

  class thumb_exec_scoreboard;
    logic [31:0] gpr [NUM_REGS];
    logic [3:0]  nzcv;
    logic        tflag;
    exec_res_t   expected_results [$];
    int          mismatch_count;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      nzcv = '0;
      tflag = 1'b1;
      mismatch_count = 0;
    endfunction

    function logic [31:0] read_operand(logic [3:0] idx, logic [31:0] pc);
      return (idx == REG_PC) ? pc : gpr[idx];
    endfunction

    function logic [3:0] nz_flags(logic [31:0] v);
      return {v[31], v == 32'd0, 2'b00};
    endfunction

    // Execute one accepted item on the shadow state and queue its result
    function void note_issue(logic [15:0] ins, logic [31:0] pc);
      exec_res_t   r;
      logic [31:0] a, b, sum, ovf, lr;
      logic [3:0]  f, rs, rd;
      r = '0;
      r.status = STATUS_OK;
      if (ins[15:11] == FMT_ADDSUB) begin
        if (ins[10:9] != ADDSUB_OP_ADD_IMM) begin
          r.status = STATUS_BAD_ADDSUB;
        end else begin
          a = gpr[ins[5:3]];
          b = {29'd0, ins[8:6]};
          sum = a + b;
          ovf = ~(a ^ b) & (a ^ sum);
          f = nz_flags(sum);
          f[FLAG_C] = sum < a;
          f[FLAG_V] = ovf[31];
          gpr[ins[2:0]] = sum;
          r.wr_en = 1'b1;
          r.wr_idx = {1'b0, ins[2:0]};
          r.wr_val = sum;
          nzcv = f;
        end
      end else if (ins[15:13] == FMT_IMM8) begin
        b = {24'd0, ins[7:0]};
        case (ins[12:11])
          IMM_OP_MOV: begin
            gpr[ins[10:8]] = b;
            r.wr_en = 1'b1;
            r.wr_idx = {1'b0, ins[10:8]};
            r.wr_val = b;
            f = nz_flags(b);
            nzcv = {f[3:2], nzcv[1:0]};
          end
          IMM_OP_CMP: begin
            a = gpr[ins[10:8]];
            sum = a - b;
            ovf = (a ^ b) & (a ^ sum);
            f = nz_flags(sum);
            f[FLAG_C] = a >= b;
            f[FLAG_V] = ovf[31];
            nzcv = f;
          end
          default: r.status = STATUS_BAD_IMM;
        endcase
      end else if (ins[15:10] == FMT_HIREG) begin
        rs = {ins[6], ins[5:3]};
        rd = {ins[7], ins[2:0]};
        case (ins[9:8])
          HI_OP_MOV: begin
            a = read_operand(rs, pc);
            if (rd == REG_PC) begin
              r.br_taken = 1'b1;
              r.br_target = {a[31:1], 1'b0};
            end else begin
              gpr[rd] = a;
              r.wr_en = 1'b1;
              r.wr_idx = rd;
              r.wr_val = a;
            end
          end
          HI_OP_BX: begin
            // read the target before the link write
            a = read_operand(rs, pc);
            if (ins[7]) begin
              lr = (pc - 32'd2) | 32'd1;
              gpr[REG_LR] = lr;
              r.wr_en = 1'b1;
              r.wr_idx = REG_LR;
              r.wr_val = lr;
            end
            r.br_taken = 1'b1;
            r.br_target = {a[31:1], 1'b0};
            tflag = a[0];
          end
          default: r.status = STATUS_BAD_HIREG;
        endcase
      end else if (ins[15:12] == FMT_ADDR) begin
        a = ins[11] ? gpr[REG_SP] : {pc[31:2], 2'b00};
        sum = a + {22'd0, ins[7:0], 2'b00};
        gpr[ins[10:8]] = sum;
        r.wr_en = 1'b1;
        r.wr_idx = {1'b0, ins[10:8]};
        r.wr_val = sum;
      end else if (ins[15:8] == FMT_SPADJ) begin
        b = {23'd0, ins[6:0], 2'b00};
        sum = ins[7] ? gpr[REG_SP] - b : gpr[REG_SP] + b;
        gpr[REG_SP] = sum;
        r.wr_en = 1'b1;
        r.wr_idx = REG_SP;
        r.wr_val = sum;
      end else begin
        r.status = STATUS_UNHANDLED;
      end
      r.flags = nzcv;
      r.tbit = tflag;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t error %s: got %h want %h", $realtime, what, got, want);
    endtask

    task check_retire(exec_res_t got);
      exec_res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd0);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.wr_en !== want.wr_en)
        report_mismatch("reg_written", 32'(got.wr_en), 32'(want.wr_en));
      if (got.wr_idx !== want.wr_idx)
        report_mismatch("dest_index", 32'(got.wr_idx), 32'(want.wr_idx));
      if (got.wr_val !== want.wr_val)
        report_mismatch("dest_value", got.wr_val, want.wr_val);
      if (got.flags !== want.flags)
        report_mismatch("flags_out", 32'(got.flags), 32'(want.flags));
      if (got.br_taken !== want.br_taken)
        report_mismatch("branch_taken", 32'(got.br_taken), 32'(want.br_taken));
      if (got.br_target !== want.br_target)
        report_mismatch("branch_target", got.br_target, want.br_target);
      if (got.tbit !== want.tbit)
        report_mismatch("thumb_mode", 32'(got.tbit), 32'(want.tbit));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] instr_word;
  logic [31:0] pc_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic        reg_written;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic [3:0]  flags_out;
  logic        branch_taken;
  logic [31:0] branch_target;
  logic        thumb_mode;

  thumb_exec_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;

  thumb_alu_subset_executor dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .instr_word    (instr_word),
    .pc_value      (pc_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .reg_written   (reg_written),
    .dest_index    (dest_index),
    .dest_value    (dest_value),
    .flags_out     (flags_out),
    .branch_taken  (branch_taken),
    .branch_target (branch_target),
    .thumb_mode    (thumb_mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    exec_res_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.status    = status_t'(status);
        got.wr_en     = reg_written;
        got.wr_idx    = dest_index;
        got.wr_val    = dest_value;
        got.flags     = flags_out;
        got.br_taken  = branch_taken;
        got.br_target = branch_target;
        got.tbit      = thumb_mode;
        sb.check_retire(got);
      end
    end
  end

  function automatic logic [15:0] imm8(logic [1:0] op, logic [2:0] rn, logic [7:0] imm);
    return {FMT_IMM8, op, rn, imm};
  endfunction

  function automatic logic [15:0] hi_op(logic [1:0] op, logic [3:0] rd, logic [3:0] rs);
    return {FMT_HIREG, op, rd[3], rs[3], rs[2:0], rd[2:0]};
  endfunction

  // Mostly well-formed supported items; the rest in-format rejects and noise
  function automatic logic [15:0] rand_instr();
    int          pick;
    logic [15:0] raw;
    pick = $urandom_range(99);
    raw = 16'($urandom);
    if (pick < 15)      return {FMT_ADDSUB, ADDSUB_OP_ADD_IMM, raw[8:0]};
    else if (pick < 30) return {FMT_IMM8, IMM_OP_MOV, raw[10:0]};
    else if (pick < 42) return {FMT_IMM8, IMM_OP_CMP, raw[10:0]};
    else if (pick < 56) return {FMT_HIREG, HI_OP_MOV, raw[7:0]};
    else if (pick < 64) return {FMT_HIREG, HI_OP_BX, raw[7:0]};
    else if (pick < 74) return {FMT_ADDR, raw[11:0]};
    else if (pick < 82) return {FMT_SPADJ, raw[7:0]};
    else if (pick < 85) return {FMT_ADDSUB, raw[10:0]};
    else if (pick < 88) return {FMT_IMM8, raw[12:0]};
    else if (pick < 91) return {FMT_HIREG, raw[9:0]};
    else                return raw;
  endfunction

  function automatic logic [31:0] rand_pc();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0)      return 32'd0;
    else if (pick == 1) return 32'hFFFF_FFFF;
    else                return $urandom;
  endfunction

  task automatic send_item(logic [15:0] ins, logic [31:0] pc);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    instr_word <= ins;
    pc_value   <= pc;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_issue(ins, pc);
  endtask

  // Hold the sender off until every pending result has retired
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(imm8(IMM_OP_MOV, 3'd0, 8'h00), 32'd0);
    send_item(imm8(IMM_OP_MOV, 3'd7, 8'hFF), 32'hFFFF_FFFF);
    send_item(imm8(IMM_OP_CMP, 3'd7, 8'hFF), 32'd0);       // equal: Z and C
    send_item(imm8(IMM_OP_CMP, 3'd0, 8'h01), 32'd0);       // borrow
    send_item(hi_op(HI_OP_MOV, 4'd1, REG_PC), 32'h7FFF_FFFF);
    send_item({FMT_ADDSUB, ADDSUB_OP_ADD_IMM, 3'd7, 3'd1, 3'd2}, 32'd0);  // signed overflow
    send_item(hi_op(HI_OP_MOV, 4'd3, REG_PC), 32'hFFFF_FFFF);
    send_item({FMT_ADDSUB, ADDSUB_OP_ADD_IMM, 3'd1, 3'd3, 3'd4}, 32'd0);  // carry out, zero
    send_item(hi_op(HI_OP_MOV, 4'd5, REG_PC), 32'h8000_0000);
    send_item(imm8(IMM_OP_CMP, 3'd5, 8'h01), 32'd0);       // overflow on compare
    send_item(hi_op(HI_OP_MOV, 4'd8, 4'd1), 32'd0);
    send_item(hi_op(HI_OP_MOV, REG_LR, 4'd3), 32'd0);
    send_item(hi_op(HI_OP_MOV, REG_PC, 4'd1), 32'h1234_5678);   // move to pc branches
    send_item(hi_op(HI_OP_BX, 4'd0, 4'd0), 32'h0000_0100);      // even target clears T
    send_item({FMT_ADDR, 1'b0, 3'd6, 8'hFF}, 32'hFFFF_FFFF);    // decode goes on with T clear
    send_item(hi_op(HI_OP_BX, 4'd8, REG_LR), 32'h0000_0002);    // link reads old r14 first
    send_item(hi_op(HI_OP_BX, 4'd8, REG_PC), 32'h0000_0001);
    send_item({FMT_SPADJ, 1'b0, 7'h7F}, 32'd0);
    send_item({FMT_SPADJ, 1'b1, 7'h7F}, 32'd0);
    send_item({FMT_SPADJ, 1'b1, 7'h7F}, 32'd0);                 // sp wraps below zero
    send_item({FMT_ADDR, 1'b1, 3'd6, 8'hFF}, 32'd0);
    send_item({FMT_ADDSUB, ADDSUB_OP_ADD_REG, 9'h1FF}, 32'd0);
    send_item({FMT_ADDSUB, ADDSUB_OP_SUB_REG, 9'h000}, 32'd0);
    send_item({FMT_ADDSUB, ADDSUB_OP_SUB_IMM, 9'h0AA}, 32'd0);
    send_item({FMT_IMM8, IMM_OP_ADD, 11'h7FF}, 32'd0);
    send_item({FMT_IMM8, IMM_OP_SUB, 11'h000}, 32'd0);
    send_item(hi_op(HI_OP_ADD, 4'd15, 4'd15), 32'd0);
    send_item(hi_op(HI_OP_CMP, 4'd0, 4'd0), 32'd0);
    send_item(16'h0000, 32'd0);
    send_item(16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(rand_instr(), rand_pc());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    instr_word = '0;
    pc_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_random(300, 0, 0);
    run_random(300, 53, 0);
    pause_until_drained();
    run_random(300, 0, 53);
    run_random(300, 33, 33);

    recv_stall_pct = 0;
    pause_until_drained();
    repeat (8) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.report_mismatch("results never arrived", 32'(sb.expected_results.size()), 32'd0);
    if (sb.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ thumb_alu_subset_executor.f @@
rtl/tase_pkg.sv
rtl/tase_exec.sv
rtl/thumb_alu_subset_executor.sv
tb/tb.sv
